### hdl/multistep_vector_integrator_macros.svh
// ----------------------------------------------------------------------------
// Multistep vector integrator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTISTEP_VECTOR_INTEGRATOR_MACROS_SVH
`define MULTISTEP_VECTOR_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define MVI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mvi_pkg.sv
// ----------------------------------------------------------------------------
// Multistep vector integrator package
// Widths, register indexes, method codes, word types and the weight table.
// ----------------------------------------------------------------------------
package mvi_pkg;

    localparam int LANES         = 4;
    localparam int HISTORY_DEPTH = 4;
    localparam int VALUE_WIDTH   = 32;
    localparam int RATE_W        = 32;
    localparam int DT_W          = 24;
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int LANE_W        = $clog2(LANES);
    localparam int TAP_W         = $clog2(HISTORY_DEPTH);

    localparam int WEIGHT_W      = 7;
    localparam int MUL_A_W       = 32;
    localparam int MUL_B_W       = DT_W + 1;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int ACC_W         = 64;
    localparam int SUM_W         = 40;
    localparam int SPLIT_W       = 20;
    localparam int HI_W          = SUM_W - SPLIT_W;
    // product scaled by 2^-24 and by 1/8; the remaining 1/3 goes to the divider
    localparam int FRAC_SHIFT    = DT_W + 3;
    localparam int U_W           = ACC_W - FRAC_SHIFT;
    localparam int QUO_W         = U_W + 1;
    localparam int DIV_W         = ((QUO_W + 3) / 4) * 4;
    localparam int INC_W         = QUO_W;
    localparam int UPD_W         = ((VALUE_WIDTH > INC_W) ? VALUE_WIDTH : INC_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_3     = 3'd5;

    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EULER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRAP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AB2   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AB3   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AB4   = 3'd5;

    localparam logic [DT_W-1:0]   STEP_SIZE_RESET = 24'd139810;
    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_EULER;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_ADD_HI
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_0;
        logic signed [RATE_W-1:0] rate_1;
        logic signed [RATE_W-1:0] rate_2;
        logic signed [RATE_W-1:0] rate_3;
        logic                     restart;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value_0;
        logic signed [VALUE_WIDTH-1:0] value_1;
        logic signed [VALUE_WIDTH-1:0] value_2;
        logic signed [VALUE_WIDTH-1:0] value_3;
        logic                          clipped;
    } out_word_t;

    // weights over 24, newest tap first
    function automatic logic signed [WEIGHT_W-1:0] ab_weight(
        input logic [MODE_W-1:0] mode,
        input logic [TAP_W-1:0]  tap
    );
        logic signed [WEIGHT_W-1:0] w;
        begin
            w = '0;
            case (mode)
                MODE_EULER:
                begin
                    if (tap == TAP_W'(0)) w = 7'sd24;
                end
                MODE_TRAP:
                begin
                    if (tap == TAP_W'(0) || tap == TAP_W'(1)) w = 7'sd12;
                end
                MODE_AB2:
                begin
                    case (tap)
                        TAP_W'(0): w = 7'sd36;
                        TAP_W'(1): w = -7'sd12;
                        default:   w = '0;
                    endcase
                end
                MODE_AB3:
                begin
                    case (tap)
                        TAP_W'(0): w = 7'sd46;
                        TAP_W'(1): w = -7'sd32;
                        TAP_W'(2): w = 7'sd10;
                        default:   w = '0;
                    endcase
                end
                MODE_AB4:
                begin
                    case (tap)
                        TAP_W'(0): w = 7'sd55;
                        TAP_W'(1): w = -7'sd59;
                        TAP_W'(2): w = 7'sd37;
                        default:   w = -7'sd9;
                    endcase
                end
                default: w = '0;
            endcase
            return w;
        end
    endfunction

endpackage

### hdl/mvi_mac.sv
// ----------------------------------------------------------------------------
// Multistep vector integrator multiply-accumulate unit
// One 32x25 signed multiplier feeding a 64-bit accumulator; hold, load, add,
// or add with the product shifted up by the split width.
// ----------------------------------------------------------------------------
module mvi_mac (
    input  logic                                 clk,
    input  mvi_pkg::mac_op_t                     op,
    input  logic signed [mvi_pkg::MUL_A_W-1:0]   a,
    input  logic signed [mvi_pkg::MUL_B_W-1:0]   b,
    output logic signed [mvi_pkg::ACC_W-1:0]     acc
);

    logic signed [mvi_pkg::PROD_W-1:0] prod;
    logic signed [mvi_pkg::ACC_W-1:0]  prod_ext;
    logic signed [mvi_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvi_pkg::ACC_W-1:0]  acc_next;

    assign prod     = a * b;
    assign prod_ext = mvi_pkg::ACC_W'(prod);

    always_comb
    begin
        case (op)
            mvi_pkg::MAC_LOAD:   acc_next = prod_ext;
            mvi_pkg::MAC_ADD:    acc_next = acc_reg + prod_ext;
            mvi_pkg::MAC_ADD_HI: acc_next = acc_reg + (prod_ext <<< mvi_pkg::SPLIT_W);
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

### hdl/mvi_div3.sv
// ----------------------------------------------------------------------------
// Multistep vector integrator divide-by-three unit
// Unsigned long division by 3, one hex digit per cycle, MSB first.
// Quotient is valid while done is high.
// ----------------------------------------------------------------------------
module mvi_div3 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mvi_pkg::DIV_W-1:0]        dividend,
    output logic                             busy,
    output logic                             done,
    output logic [mvi_pkg::DIV_W-1:0]        quotient
);

    localparam int DIGIT_W = 4;
    localparam int DIGITS  = mvi_pkg::DIV_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);

    // {quotient digit, remainder} of ({rem, digit}) / 3
    function automatic logic [DIGIT_W+1:0] div3_digit(input logic [DIGIT_W+1:0] x);
        logic [DIGIT_W+1:0] r;
        logic [DIGIT_W-1:0] q;
        begin
            r = x;
            q = '0;
            for (int i = DIGIT_W - 1; i >= 0; i--)
            begin
                if (r >= ((DIGIT_W + 2)'(3) << i))
                begin
                    r    = r - ((DIGIT_W + 2)'(3) << i);
                    q[i] = 1'b1;
                end
            end
            return {q, r[1:0]};
        end
    endfunction

    logic [mvi_pkg::DIV_W-1:0] work_reg;
    logic [1:0]                rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DIGIT_W+1:0]        step;

    assign step = div3_digit({rem_reg, work_reg[mvi_pkg::DIV_W-1 -: DIGIT_W]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIGITS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIGITS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[mvi_pkg::DIV_W-DIGIT_W-1:0], step[DIGIT_W+1:2]};
            rem_reg  <= step[1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

### hdl/multistep_vector_integrator.sv
// ----------------------------------------------------------------------------
// Multistep vector integrator
// Four-lane Adams-Bashforth integrator, orders 1 to 4, plus a trapezoidal mode, with saturation.
//
//   channel  | dir | handshake           | word
//   ---------+-----+---------------------+----------------------------------
//   in       | in  | in_valid / in_stall | rate_0..3, restart
//   out      | out | out_valid/out_stall | value_0..3, clipped
//   cfg      | in  | cfg_we              | cfg_index, cfg_data
//
// Each word runs the four lanes in turn, each through one MAC step per tap,
// the low and high dt multiply steps, the divider start, the radix-16
// divide-by-3 unit and the update, on the shared multiplier and divider.
// in_stall is high from acceptance until the result word is loaded.
// Reset is asynchronous; it clears history, integrand and config to defaults.
// A stalled result word holds; the block finishes its next word only once
// the output register is free.
// ----------------------------------------------------------------------------
`include "multistep_vector_integrator_macros.svh"

module multistep_vector_integrator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mvi_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mvi_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [mvi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VW    = mvi_pkg::VALUE_WIDTH;
    localparam int UPD_W = mvi_pkg::UPD_W;

    localparam logic signed [UPD_W-1:0] VAL_MAX =
        {{(UPD_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [UPD_W-1:0] VAL_MIN = ~VAL_MAX;
    localparam logic [mvi_pkg::QUO_W-1:0] DIV_BIAS =
        mvi_pkg::QUO_W'(3) << (mvi_pkg::U_W - 1);
    localparam logic [mvi_pkg::QUO_W-1:0] INC_BIAS =
        mvi_pkg::QUO_W'(1) << (mvi_pkg::U_W - 1);

    function automatic logic signed [VW-1:0] sat_value(input logic signed [UPD_W-1:0] v);
        begin
            if (v > VAL_MAX)
                return VAL_MAX[VW-1:0];
            else if (v < VAL_MIN)
                return VAL_MIN[VW-1:0];
            else
                return v[VW-1:0];
        end
    endfunction

    // config
    logic [mvi_pkg::DT_W-1:0]          step_size_reg;
    logic [mvi_pkg::MODE_W-1:0]        mode_reg;
    logic signed [mvi_pkg::RATE_W-1:0] start_reg [mvi_pkg::LANES];

    // state
    logic signed [mvi_pkg::RATE_W-1:0] hist_reg [mvi_pkg::HISTORY_DEPTH][mvi_pkg::LANES];
    logic signed [VW-1:0]              integrand_reg [mvi_pkg::LANES];
    logic signed [mvi_pkg::RATE_W-1:0] rate_in [mvi_pkg::LANES];

    mvi_pkg::state_t                   state_reg, state_next;
    logic [mvi_pkg::LANE_W-1:0]        lane_reg, lane_next;
    logic [mvi_pkg::TAP_W-1:0]         tap_reg, tap_next;
    logic signed [mvi_pkg::HI_W-1:0]   sum_hi_reg;
    logic                              clipped_reg;
    logic                              out_valid_reg, out_valid_next;
    mvi_pkg::out_word_t                out_data_reg, out_word;

    logic                              accept;
    logic                              upd_en;
    logic                              out_load;

    // shared datapath
    mvi_pkg::mac_op_t                     mac_op;
    logic signed [mvi_pkg::MUL_A_W-1:0]   mac_a;
    logic signed [mvi_pkg::MUL_B_W-1:0]   mac_b;
    logic signed [mvi_pkg::ACC_W-1:0]     mac_acc;

    logic                                 div_start;
    logic                                 div_busy;
    logic                                 div_done;
    logic [mvi_pkg::DIV_W-1:0]            div_quotient;
    logic [mvi_pkg::DIV_W-1:0]            div_dividend;
    logic [mvi_pkg::U_W-1:0]              scaled;
    logic [mvi_pkg::QUO_W-1:0]            biased;
    logic signed [mvi_pkg::INC_W-1:0]     inc;
    logic signed [UPD_W-1:0]              upd_sum;

    mvi_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    mvi_div3 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rate_in[0] = in_data.rate_0;
    assign rate_in[1] = in_data.rate_1;
    assign rate_in[2] = in_data.rate_2;
    assign rate_in[3] = in_data.rate_3;

    assign in_stall = (state_reg != mvi_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // floor(P / 2^27), biased non-negative for the unsigned divide by 3
    assign scaled       = mac_acc[mvi_pkg::ACC_W-1:mvi_pkg::FRAC_SHIFT];
    assign biased       = {scaled[mvi_pkg::U_W-1], scaled} + DIV_BIAS;
    assign div_dividend = mvi_pkg::DIV_W'(biased);
    assign inc          = $signed(div_quotient[mvi_pkg::INC_W-1:0] - INC_BIAS);
    assign upd_sum      = UPD_W'(integrand_reg[lane_reg]) + UPD_W'(inc);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        tap_next   = tap_reg;
        mac_op     = mvi_pkg::MAC_HOLD;
        mac_a      = '0;
        mac_b      = '0;
        div_start  = 1'b0;
        upd_en     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mvi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mvi_pkg::ST_MAC;
                    lane_next  = '0;
                    tap_next   = '0;
                end
            end
            mvi_pkg::ST_MAC:
            begin
                mac_op   = (tap_reg == '0) ? mvi_pkg::MAC_LOAD : mvi_pkg::MAC_ADD;
                mac_a    = hist_reg[tap_reg][lane_reg];
                mac_b    = mvi_pkg::MUL_B_W'(mvi_pkg::ab_weight(mode_reg, tap_reg));
                tap_next = tap_reg + mvi_pkg::TAP_W'(1);
                if (tap_reg == mvi_pkg::TAP_W'(mvi_pkg::HISTORY_DEPTH - 1))
                    state_next = mvi_pkg::ST_MUL_LO;
            end
            mvi_pkg::ST_MUL_LO:
            begin
                mac_op     = mvi_pkg::MAC_LOAD;
                mac_a      = $signed(mvi_pkg::MUL_A_W'(mac_acc[mvi_pkg::SPLIT_W-1:0]));
                mac_b      = $signed({1'b0, step_size_reg});
                state_next = mvi_pkg::ST_MUL_HI;
            end
            mvi_pkg::ST_MUL_HI:
            begin
                mac_op     = mvi_pkg::MAC_ADD_HI;
                mac_a      = mvi_pkg::MUL_A_W'(sum_hi_reg);
                mac_b      = $signed({1'b0, step_size_reg});
                state_next = mvi_pkg::ST_DIV_START;
            end
            mvi_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = mvi_pkg::ST_DIV_WAIT;
            end
            mvi_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = mvi_pkg::ST_UPDATE;
            end
            mvi_pkg::ST_UPDATE:
            begin
                upd_en = 1'b1;
                if (lane_reg == mvi_pkg::LANE_W'(mvi_pkg::LANES - 1))
                    state_next = mvi_pkg::ST_DONE;
                else
                begin
                    lane_next  = lane_reg + mvi_pkg::LANE_W'(1);
                    tap_next   = '0;
                    state_next = mvi_pkg::ST_MAC;
                end
            end
            mvi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = mvi_pkg::ST_IDLE;
                end
            end
            default: state_next = mvi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvi_pkg::ST_IDLE;
            lane_reg  <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mvi_pkg::ST_MUL_LO)
            sum_hi_reg <= mac_acc[mvi_pkg::SUM_W-1:mvi_pkg::SPLIT_W];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= mvi_pkg::STEP_SIZE_RESET;
            mode_reg      <= mvi_pkg::MODE_RESET;
            for (int k = 0; k < mvi_pkg::LANES; k++)
                start_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvi_pkg::REG_STEP_SIZE:   step_size_reg <= cfg_data[mvi_pkg::DT_W-1:0];
                mvi_pkg::REG_METHOD_MODE: mode_reg      <= cfg_data[mvi_pkg::MODE_W-1:0];
                mvi_pkg::REG_START_0:     start_reg[0]  <= $signed(cfg_data[mvi_pkg::RATE_W-1:0]);
                mvi_pkg::REG_START_1:     start_reg[1]  <= $signed(cfg_data[mvi_pkg::RATE_W-1:0]);
                mvi_pkg::REG_START_2:     start_reg[2]  <= $signed(cfg_data[mvi_pkg::RATE_W-1:0]);
                mvi_pkg::REG_START_3:     start_reg[3]  <= $signed(cfg_data[mvi_pkg::RATE_W-1:0]);
                default:                  ;
            endcase
        end
    end

    // history: restart fills every tap, otherwise shift in the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < mvi_pkg::HISTORY_DEPTH; d++)
                for (int k = 0; k < mvi_pkg::LANES; k++)
                    hist_reg[d][k] <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < mvi_pkg::LANES; k++)
            begin
                hist_reg[0][k] <= rate_in[k];
                for (int d = 1; d < mvi_pkg::HISTORY_DEPTH; d++)
                    hist_reg[d][k] <= in_data.restart ? rate_in[k] : hist_reg[d-1][k];
            end
        end
    end

    // integrand and clip flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mvi_pkg::LANES; k++)
                integrand_reg[k] <= '0;
            clipped_reg <= 1'b0;
        end
        else if (accept)
        begin
            clipped_reg <= 1'b0;
            if (in_data.restart)
                for (int k = 0; k < mvi_pkg::LANES; k++)
                    integrand_reg[k] <= sat_value(UPD_W'(start_reg[k]));
        end
        else if (upd_en)
        begin
            integrand_reg[lane_reg] <= sat_value(upd_sum);
            if (upd_sum > VAL_MAX || upd_sum < VAL_MIN)
                clipped_reg <= 1'b1;
        end
    end

    // result word register
    always_comb
    begin
        out_word.value_0 = integrand_reg[0];
        out_word.value_1 = integrand_reg[1];
        out_word.value_2 = integrand_reg[2];
        out_word.value_3 = integrand_reg[3];
        out_word.clipped = clipped_reg;
        out_valid_next   = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MVI_ASSERT_NEXT(a_accept_starts_lane0, accept, state_reg == mvi_pkg::ST_MAC && lane_reg == '0 && tap_reg == '0, "accepted word did not start at lane 0 tap 0")
    `MVI_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == mvi_pkg::ST_DIV_WAIT, "divider finished outside the wait state")
    `MVI_ASSERT_IMP(a_wait_has_divider, state_reg == mvi_pkg::ST_DIV_WAIT, div_busy || div_done, "waiting on an idle divider")
    `MVI_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state_reg == mvi_pkg::ST_DONE), "result word loaded outside the done state")

endmodule
